// ===== src/mmtb_pkg.sv =====
// Shared constants and types for the transposed-B matrix multiplier.
`timescale 1ns / 1ps

package mmtb_pkg;

    // Largest matrix dimension held in the element stores.
    localparam int MAX_DIM    = 16;
    // Width of one stored matrix element (signed Q8.8).
    localparam int ELEM_WIDTH = 16;

    localparam int DIM_BITS   = $clog2(MAX_DIM);
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = 2 * DIM_BITS;
    localparam int CFG_W      = 5;
    localparam int PROD_W     = 2 * ELEM_WIDTH;
    localparam int ACC_W      = 40;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ROWS  = 2'd0,
        CFG_COLS  = 2'd1,
        CFG_INNER = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } state_t;

endpackage

// ===== src/mmtb_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module mmtb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/matrix_multiply_transposed_b.sv =====
// Top level of the dense matrix multiplier with B held in transposed form.
`timescale 1ns / 1ps

// Dense matrix multiply C = A x B over signed Q8.8 elements. Input transfers
// carry an operation in tuser: write an element of A, write an element of B
// (stored transposed so that each column of B is one contiguous line), or
// compute one row of C. Element writes are taken one per cycle while no
// compute is in progress. A compute transfer for row i holds the input side
// until every column of the row has been handed over, and also waits while
// the output side stalls: each column issues one read of A and of B per
// inner step through a single read port on each store, then passes through
// the RAM read register, the product register and the final accumulation,
// after which the sum is handed over into the output register. Each result
// is the full 40-bit Q24.16 dot product, with tlast set on the final column
// of the row. A compute transfer whose row is not below rows_in_use produces
// nothing, as does the unused operation code.
// Configuration registers saturate: zero counts as one and values above
// the store size count as the store size. Writes and reads of the stores
// never overlap in time, so no forwarding is needed between them. An
// element that was never written reads back as whatever the RAM holds.

module matrix_multiply_transposed_b (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row [3:0], col [7:4], value [23:8]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // product_value [39:0], out_row [43:40],
                                   // out_col [47:44]
    output logic        m_tlast,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int DB = mmtb_pkg::DIM_BITS;
    localparam int AW = mmtb_pkg::ADDR_W;
    localparam int EW = mmtb_pkg::ELEM_WIDTH;
    localparam int CW = mmtb_pkg::CFG_W;
    localparam int PW = mmtb_pkg::PROD_W;
    localparam int XW = mmtb_pkg::ACC_W;

    // Saturate a dimension register into the range one to MAX_DIM.
    function automatic logic [CW-1:0] clamp_dim(input logic [CW-1:0] r);
        logic [CW-1:0] res;
        if (r == '0)
        begin
            res = CW'(1);
        end
        else if (r > CW'(mmtb_pkg::MAX_DIM))
        begin
            res = CW'(mmtb_pkg::MAX_DIM);
        end
        else
        begin
            res = r;
        end
        return res;
    endfunction

    // Input field unpacking.
    mmtb_pkg::op_t  in_op;
    logic [DB-1:0]  in_row;
    logic [DB-1:0]  in_col;
    logic [EW-1:0]  in_value;

    assign in_op    = mmtb_pkg::op_t'(s_tuser);
    assign in_row   = s_tdata[DB-1:0];
    assign in_col   = s_tdata[2*DB-1:DB];
    assign in_value = s_tdata[2*DB+EW-1:2*DB];

    // Configuration registers, held already saturated.
    logic [CW-1:0] rows_reg;
    logic [CW-1:0] cols_reg;
    logic [CW-1:0] inner_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= CW'(mmtb_pkg::MAX_DIM);
            cols_reg  <= CW'(mmtb_pkg::MAX_DIM);
            inner_reg <= CW'(mmtb_pkg::MAX_DIM);
        end
        else if (cfg_we)
        begin
            unique case (mmtb_pkg::cfg_idx_t'(cfg_index))
                mmtb_pkg::CFG_ROWS:  rows_reg  <= clamp_dim(cfg_data);
                mmtb_pkg::CFG_COLS:  cols_reg  <= clamp_dim(cfg_data);
                mmtb_pkg::CFG_INNER: inner_reg <= clamp_dim(cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer state.
    mmtb_pkg::state_t state_reg, state_next;
    logic [DB-1:0] row_reg, row_next;
    logic [DB-1:0] col_reg, col_next;
    logic [DB-1:0] k_reg, k_next;

    // Pipeline through the stores and the multiplier.
    logic                 rd_v_reg;
    logic                 rd_last_reg;
    logic                 prod_v_reg;
    logic                 prod_last_reg;
    logic signed [PW-1:0] prod_reg;
    logic [XW-1:0]        acc_reg;
    logic                 acc_done_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [XW-1:0]        m_value_reg;
    logic [DB-1:0]        m_row_reg;
    logic [DB-1:0]        m_col_reg;
    logic                 m_last_reg;

    // Control decodes.
    logic          in_fire;
    logic          start;
    logic          issue;
    logic          k_last;
    logic          col_last;
    logic          out_free;
    logic          load_out;
    logic          a_we;
    logic          b_we;
    logic [AW-1:0] a_raddr;
    logic [AW-1:0] b_raddr;
    logic [EW-1:0] a_rdata;
    logic [EW-1:0] b_rdata;

    assign in_fire  = s_tvalid && s_tready;
    assign k_last   = ({1'b0, k_reg} + CW'(1)) == inner_reg;
    assign col_last = ({1'b0, col_reg} + CW'(1)) == cols_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Outputs of the sequencer.
    always_comb
    begin
        s_tready = 1'b0;
        start    = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        a_we     = 1'b0;
        b_we     = 1'b0;
        unique case (state_reg)
            mmtb_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (in_op)
                        mmtb_pkg::OP_WRITE_A: a_we = 1'b1;
                        mmtb_pkg::OP_WRITE_B: b_we = 1'b1;
                        mmtb_pkg::OP_COMPUTE: start = {1'b0, in_row} < rows_reg;
                        default: ;
                    endcase
                end
            end
            mmtb_pkg::ST_ISSUE:
            begin
                issue = 1'b1;
            end
            mmtb_pkg::ST_WAIT:
            begin
                load_out = acc_done_reg && out_free;
            end
            default: ;
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        unique case (state_reg)
            mmtb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mmtb_pkg::ST_ISSUE;
                    row_next   = in_row;
                    col_next   = '0;
                    k_next     = '0;
                end
            end
            mmtb_pkg::ST_ISSUE:
            begin
                k_next = k_reg + DB'(1);
                if (k_last)
                begin
                    state_next = mmtb_pkg::ST_WAIT;
                end
            end
            mmtb_pkg::ST_WAIT:
            begin
                if (load_out)
                begin
                    k_next = '0;
                    if (col_last)
                    begin
                        state_next = mmtb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mmtb_pkg::ST_ISSUE;
                        col_next   = col_reg + DB'(1);
                    end
                end
            end
            default:
            begin
                state_next = mmtb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmtb_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

    // A is addressed row-major; B is kept transposed, column-major.
    assign a_raddr = {row_reg, k_reg};
    assign b_raddr = {col_reg, k_reg};

    mmtb_ram #(
        .WIDTH (EW),
        .DEPTH (mmtb_pkg::DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we && in_fire),
        .waddr ({in_row, in_col}),
        .wdata (in_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mmtb_ram #(
        .WIDTH (EW),
        .DEPTH (mmtb_pkg::DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we && in_fire),
        .waddr ({in_col, in_row}),
        .wdata (in_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Valid tags follow each read through the RAM and multiplier stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_v_reg    <= 1'b0;
            prod_last_reg <= 1'b0;
            acc_reg       <= '0;
            acc_done_reg  <= 1'b0;
        end
        else
        begin
            rd_v_reg      <= issue;
            rd_last_reg   <= issue && k_last;
            prod_v_reg    <= rd_v_reg;
            prod_last_reg <= rd_last_reg;
            // The first read of a column clears the accumulator; its product
            // arrives through the read and product registers, after the previous column has left.
            if (issue && (k_reg == '0))
            begin
                acc_reg <= '0;
            end
            else if (prod_v_reg)
            begin
                acc_reg <= acc_reg + {{(XW - PW){prod_reg[PW-1]}}, prod_reg};
            end
            if (prod_v_reg && prod_last_reg)
            begin
                acc_done_reg <= 1'b1;
            end
            else if (load_out)
            begin
                acc_done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(a_rdata) * $signed(b_rdata);
    end

    // Result register: a finished dot product waits here for the transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_value_reg <= acc_reg;
            m_row_reg   <= row_reg;
            m_col_reg   <= col_reg;
            m_last_reg  <= col_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_col_reg, m_row_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the transposed-B matrix multiplier.
`timescale 1ns / 1ps

module tb_top;

    // The spare operation code, which the block must swallow without a result.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Quiet time after draining; it outlasts the slowest compute transfer, so
    // it is enough for any work still in flight to finish.
    localparam int SETTLE_CYCLES = 400;
    // Length of the single long receiver hold-off.
    localparam int HOLD_CYCLES   = 600;
    // Cycles without any transfer or register write before the run is declared hung.
    localparam int STALL_LIMIT   = 4000;

    // One input transfer as the driver sends it.
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] value;
    } transfer_t;

    // One element of C as the block should deliver it.
    typedef struct packed {
        logic [39:0] value;
        logic [3:0]  row;
        logic [3:0]  col;
        logic        last;
    } product_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // row [3:0], col [7:4], value [23:8]
    logic [1:0]  s_tuser   = '0;   // operation [1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // product_value [39:0], out_row [43:40],
                                   // out_col [47:44]
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data  = '0;

    matrix_multiply_transposed_b u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Transfers waiting to be sent, and C elements waiting to be received.
    transfer_t stim_backlog[$];
    product_t  expected_products[$];

    // Set by the stimulus for the stream processes; the mismatch count is kept by the monitor.
    bit steady_mode = 1'b0;   // no random idling on either side while set
    bit hold_req    = 1'b0;   // asks the receiver for its long hold-off
    int mismatches  = 0;

    // ------------------------------------------------------------------
    // Predictor: its own copy of both element stores and the registers.
    // ------------------------------------------------------------------
    logic signed [15:0] a_elems [0:mmtb_pkg::DEPTH-1];
    // B column j is b_cols[j*MAX_DIM +: MAX_DIM]
    logic signed [15:0] b_cols  [0:mmtb_pkg::DEPTH-1];
    logic [4:0]         rows_reg  = 5'd16;
    logic [4:0]         cols_reg  = 5'd16;
    logic [4:0]         inner_reg = 5'd16;

    // Registers saturate: zero reads as one, anything above the store size as the size.
    function automatic int dim_of(logic [4:0] raw);
        if (raw == 5'd0)
            return 1;
        if (raw > mmtb_pkg::MAX_DIM)
            return mmtb_pkg::MAX_DIM;
        return int'(raw);
    endfunction

    // Exact dot product of A row r and B column j, kept to the 40-bit accumulator.
    function automatic logic [39:0] dot_product(int r, int j);
        longint sum = 0;
        for (int k = 0; k < dim_of(inner_reg); k++)
            sum += longint'(a_elems[r*mmtb_pkg::MAX_DIM + k]) *
                   longint'(b_cols[j*mmtb_pkg::MAX_DIM + k]);
        return sum[39:0];
    endfunction

    task automatic predict_transfer(logic [1:0] op, logic [23:0] data);
        int       r;
        int       c;
        int       n_cols;
        product_t p;
        r = int'(data[3:0]);
        c = int'(data[7:4]);
        n_cols = dim_of(cols_reg);
        case (op)
            mmtb_pkg::OP_WRITE_A: a_elems[r*mmtb_pkg::MAX_DIM + c] = data[23:8];
            mmtb_pkg::OP_WRITE_B: b_cols[c*mmtb_pkg::MAX_DIM + r]  = data[23:8];
            mmtb_pkg::OP_COMPUTE:
            begin
                // A row outside the rows in use produces nothing at all.
                if (r < dim_of(rows_reg))
                begin
                    for (int j = 0; j < n_cols; j++)
                    begin
                        p.value = dot_product(r, j);
                        p.row   = data[3:0];
                        p.col   = 4'(j);
                        p.last  = (j == n_cols - 1);
                        expected_products.push_back(p);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_product();
        product_t want;
        if (expected_products.size() == 0)
        begin
            $error("unexpected result transfer: out_row %0d out_col %0d product_value %0d",
                   m_tdata[43:40], m_tdata[47:44], $signed(m_tdata[39:0]));
            mismatches++;
        end
        else
        begin
            want = expected_products.pop_front();
            if (m_tdata[39:0] !== want.value)
            begin
                $error("product_value: expected %0d, actual %0d",
                       $signed(want.value), $signed(m_tdata[39:0]));
                mismatches++;
            end
            if (m_tdata[43:40] !== want.row)
            begin
                $error("out_row: expected %0d, actual %0d", want.row, m_tdata[43:40]);
                mismatches++;
            end
            if (m_tdata[47:44] !== want.col)
            begin
                $error("out_col: expected %0d, actual %0d", want.col, m_tdata[47:44]);
                mismatches++;
            end
            if (m_tlast !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, m_tlast);
                mismatches++;
            end
        end
    endtask

    // Monitor. Everything is sampled at the rising edge, so the values seen are
    // the ones that were present when the transfer or register write happened.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_transfer(s_tuser, s_tdata);
            if (cfg_we)
            begin
                case (cfg_index)
                    mmtb_pkg::CFG_ROWS:  rows_reg  = cfg_data;
                    mmtb_pkg::CFG_COLS:  cols_reg  = cfg_data;
                    mmtb_pkg::CFG_INNER: inner_reg = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_product();
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers the backlog one transfer at a time, idling at random.
    // A new transfer is only loaded once the current one has been taken.
    // ------------------------------------------------------------------
    transfer_t next_tx;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (stim_backlog.size() != 0 && (steady_mode || $urandom_range(99) >= 33))
            begin
                next_tx = stim_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_tx.value, next_tx.col, next_tx.row};
                s_tuser  <= next_tx.op;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off when asked for it.
    // The hold-off is counted here so that the sender keeps going meanwhile.
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= steady_mode || ($urandom_range(99) >= 33);
        end
    end

    // Watchdog: ends the run if nothing at all moves for too long.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. The generator keeps its own view of the sizes in use and of
    // which store entries have been written, so that a compute never reads
    // an element that was never loaded.
    // ------------------------------------------------------------------
    int gen_rows  = 16;
    int gen_cols  = 16;
    int gen_inner = 16;
    bit a_loaded [0:mmtb_pkg::DEPTH-1];
    bit b_loaded [0:mmtb_pkg::DEPTH-1];   // indexed as column * MAX_DIM + inner index
    int phase_count;            // transfers this phase that the block acts on

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic push_item(logic [1:0] op, int row, int col, logic [15:0] value);
        transfer_t t;
        t.op    = op;
        t.row   = 4'(row);
        t.col   = 4'(col);
        t.value = value;
        stim_backlog.push_back(t);
        if (op == mmtb_pkg::OP_WRITE_A)
            a_loaded[row*mmtb_pkg::MAX_DIM + col] = 1'b1;
        if (op == mmtb_pkg::OP_WRITE_B)
            b_loaded[col*mmtb_pkg::MAX_DIM + row] = 1'b1;
        // The spare code and computes on rows out of use are merely ignored.
        if (op == mmtb_pkg::OP_WRITE_A || op == mmtb_pkg::OP_WRITE_B ||
            (op == mmtb_pkg::OP_COMPUTE && row < gen_rows))
            phase_count++;
    endtask

    // Register writes go out on the rising edge, and cfg_we drops again before the next write.
    task automatic write_cfg(mmtb_pkg::cfg_idx_t idx, logic [4:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            mmtb_pkg::CFG_ROWS:  gen_rows  = dim_of(value);
            mmtb_pkg::CFG_COLS:  gen_cols  = dim_of(value);
            mmtb_pkg::CFG_INNER: gen_inner = dim_of(value);
            default: ;
        endcase
    endtask

    // Wait until every transfer is sent and every C element received, then
    // give any compute that produces nothing time to finish as well.
    task automatic settle();
        do
            @(negedge clk);
        while (stim_backlog.size() != 0 || s_tvalid || expected_products.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Load whatever row r of C still needs, then overwrite a few needed
    // elements with fresh values so that later computes see new data.
    task automatic prepare_row(int r);
        for (int k = 0; k < gen_inner; k++)
            if (!a_loaded[r*mmtb_pkg::MAX_DIM + k])
                push_item(mmtb_pkg::OP_WRITE_A, r, k, rand_elem());
        for (int j = 0; j < gen_cols; j++)
            for (int k = 0; k < gen_inner; k++)
                if (!b_loaded[j*mmtb_pkg::MAX_DIM + k])
                    push_item(mmtb_pkg::OP_WRITE_B, k, j, rand_elem());
        repeat ($urandom_range(2))
            push_item(mmtb_pkg::OP_WRITE_A, r, $urandom_range(gen_inner - 1), rand_elem());
        repeat ($urandom_range(2))
            push_item(mmtb_pkg::OP_WRITE_B, $urandom_range(gen_inner - 1),
                      $urandom_range(gen_cols - 1), rand_elem());
    endtask

    // One phase: drain, set new sizes while the block is idle, then queue a
    // mix of complete load-and-compute sequences and noise.
    task automatic run_phase(logic [4:0] rows, logic [4:0] cols, logic [4:0] inner,
                             int budget, bit calm, bit with_hold);
        int r;
        int roll;
        settle();
        write_cfg(mmtb_pkg::CFG_ROWS, rows);
        write_cfg(mmtb_pkg::CFG_COLS, cols);
        write_cfg(mmtb_pkg::CFG_INNER, inner);
        @(negedge clk);
        steady_mode = calm;
        hold_req    = with_hold;
        phase_count = 0;
        while (phase_count < budget)
        begin
            roll = $urandom_range(99);
            r    = $urandom_range(15);
            if (roll < 70 && r < gen_rows)
            begin
                prepare_row(r);
                push_item(mmtb_pkg::OP_COMPUTE, r, $urandom_range(15),
                          16'($urandom_range(65535)));
            end
            else if (roll < 85)
            begin
                // A stray write anywhere in either store.
                push_item($urandom_range(1) ? mmtb_pkg::OP_WRITE_B : mmtb_pkg::OP_WRITE_A,
                          $urandom_range(15), $urandom_range(15), rand_elem());
            end
            else if (roll < 93)
            begin
                push_item(OP_SPARE, $urandom_range(15), $urandom_range(15),
                          16'($urandom_range(65535)));
            end
            else if (gen_rows < mmtb_pkg::MAX_DIM)
            begin
                push_item(mmtb_pkg::OP_COMPUTE, $urandom_range(mmtb_pkg::MAX_DIM - 1, gen_rows),
                          $urandom_range(15), 16'($urandom_range(65535)));
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part. Rows register zero counts as one row, two columns,
        // inner dimension one: each C element is a single product.
        write_cfg(mmtb_pkg::CFG_ROWS, 5'd0);
        write_cfg(mmtb_pkg::CFG_COLS, 5'd2);
        write_cfg(mmtb_pkg::CFG_INNER, 5'd1);
        @(negedge clk);
        push_item(mmtb_pkg::OP_WRITE_A, 0, 0, 16'h7FFF);
        push_item(mmtb_pkg::OP_WRITE_B, 0, 0, 16'h8000);
        push_item(mmtb_pkg::OP_WRITE_B, 0, 1, 16'h7FFF);
        push_item(mmtb_pkg::OP_COMPUTE, 0, 0, 16'h0000);
        // Row one is beyond the single row in use: nothing may come out.
        push_item(mmtb_pkg::OP_COMPUTE, 1, 15, 16'hFFFF);
        // The spare operation code with every field bit set is ignored.
        push_item(OP_SPARE, 15, 15, 16'hFFFF);
        // Writes at the far corner of both stores, not in use at these sizes.
        push_item(mmtb_pkg::OP_WRITE_A, 15, 15, 16'hFFFF);
        push_item(mmtb_pkg::OP_WRITE_B, 15, 15, 16'h8000);
        // Most negative times most negative, and the sign of a product with zero.
        push_item(mmtb_pkg::OP_WRITE_A, 0, 0, 16'h8000);
        push_item(mmtb_pkg::OP_WRITE_B, 0, 1, 16'h0000);
        push_item(mmtb_pkg::OP_COMPUTE, 0, 15, 16'h8000);
        push_item(mmtb_pkg::OP_WRITE_A, 0, 0, 16'hFFFF);
        push_item(mmtb_pkg::OP_WRITE_B, 0, 1, 16'h7FFF);
        push_item(mmtb_pkg::OP_COMPUTE, 0, 0, 16'h7FFF);

        // Random part. The first phase saturates the rows register from above
        // and the inner register from below, and carries the long hold-off.
        run_phase(5'd31, 5'd16, 5'd0, 20, 1'b0, 1'b1);
        run_phase(5'd4, 5'd1, 5'd17, 20, 1'b0, 1'b0);
        run_phase(5'd3, 5'd3, 5'd4, 18, 1'b0, 1'b0);
        run_phase(5'd16, 5'd2, 5'd2, 20, 1'b1, 1'b0);
        run_phase(5'($urandom_range(31)), 5'($urandom_range(4, 1)),
                  5'($urandom_range(4, 1)), 20, 1'b0, 1'b0);
        run_phase(5'd16, 5'd16, 5'd2, 20, 1'b0, 1'b0);

        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
